// ===== sv/atl_pkg.sv =====
// ----------------------------------------------------------------------------
// atl_pkg: shared types and constants for the tilt angle pipeline
// Vector word layout, CORDIC arctangent table and the rounding/saturation
// helper used by the roll and pitch output stages.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int FRAC_BITS = 14;
  localparam int VEC_W     = 33;
  localparam int ACC_W     = 33;
  localparam int SIDE_W    = 16;
  localparam int TABLE_LEN = 24;
  localparam int TAB_W     = 30;

  localparam logic signed [17:0]      GAIN_INV     = 18'sd39797;
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 33'sd589824000;
  localparam logic signed [ACC_W:0]   ROUND_HALF   = 34'sd32768;

  localparam logic signed [15:0] ROLL_LIM  = 16'sd18000;
  localparam logic signed [15:0] PITCH_LIM = 16'sd9000;

  // atan(2^-i) in centidegrees scaled by 2^16.
  localparam logic [TAB_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507,
    30'd23437865,  30'd11730358,  30'd5866610,  30'd2933484,
    30'd1466764,   30'd733385,    30'd366693,   30'd183346,
    30'd91673,     30'd45837,     30'd22918,    30'd11459,
    30'd5730,      30'd2865,      30'd1432,     30'd716,
    30'd358,       30'd179,       30'd90,       30'd45
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
    logic [SIDE_W-1:0]       side;
  } atl_vec_t;

  // Round to whole centidegrees (ties up) and clamp to +-lim.
  function automatic logic signed [15:0] atl_round_sat(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [15:0]      lim
  );
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-16:0] r;
    logic signed [ACC_W-16:0] lim_w;
    logic signed [15:0]       res;
    sum   = {acc[ACC_W-1], acc} + ROUND_HALF;
    r     = $signed(sum[ACC_W:16]);
    lim_w = (ACC_W-15)'(lim);
    if (r > lim_w) begin
      res = lim;
    end else if (r < -lim_w) begin
      res = -lim;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/atl_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// atl_cordic_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis by atan(2^-STEP) and registers the
// result, with its own valid bit and a ready toward the previous cell.
// ----------------------------------------------------------------------------
module atl_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  atl_pkg::atl_vec_t in_vec,
  output logic             out_valid,
  input  logic             out_ready,
  output atl_pkg::atl_vec_t out_vec
);
  import atl_pkg::*;

  logic                    valid_r, valid_nxt;
  atl_vec_t                vec_r, vec_nxt;
  logic                    load;
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ACC_W-1:0] tab;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;
  assign tab      = ACC_W'(ATAN_TAB[STEP]);

  always_comb begin
    xs      = in_vec.x >>> STEP;
    ys      = in_vec.y >>> STEP;
    vec_nxt = in_vec;
    if (!in_vec.y[VEC_W-1]) begin
      vec_nxt.x   = in_vec.x + ys;
      vec_nxt.y   = in_vec.y - xs;
      vec_nxt.acc = in_vec.acc + tab;
    end else begin
      vec_nxt.x   = in_vec.x - ys;
      vec_nxt.y   = in_vec.y + xs;
      vec_nxt.acc = in_vec.acc - tab;
    end
  end

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

// ===== sv/atl_cordic.sv =====
// ----------------------------------------------------------------------------
// atl_cordic: vectoring CORDIC chain
// A quadrant stage folds the left half plane into the right one and flags
// the all-zero vector, then STEPS cells each perform one iteration.
// ----------------------------------------------------------------------------
module atl_cordic #(
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [atl_pkg::VEC_W-1:0] in_x,
  input  logic signed [atl_pkg::VEC_W-1:0] in_y,
  input  logic [atl_pkg::SIDE_W-1:0]       in_side,
  output logic                            out_valid,
  input  logic                            out_ready,
  output atl_pkg::atl_vec_t               out_vec
);
  import atl_pkg::*;

  atl_vec_t vec_c [0:STEPS];
  logic     vld_c [0:STEPS];
  logic     rdy_c [0:STEPS];

  logic     valid_r, valid_nxt;
  atl_vec_t vec_r, vec_nxt;
  logic     load;

  assign in_ready = !valid_r || rdy_c[0];
  assign load     = in_valid && in_ready;

  always_comb begin
    vec_nxt.x    = in_x;
    vec_nxt.y    = in_y;
    vec_nxt.acc  = '0;
    vec_nxt.zero = (in_x == '0) && (in_y == '0);
    vec_nxt.side = in_side;
    if (in_x[VEC_W-1]) begin
      if (!in_y[VEC_W-1]) begin
        vec_nxt.x   = in_y;
        vec_nxt.y   = -in_x;
        vec_nxt.acc = QUARTER_TURN;
      end else begin
        vec_nxt.x   = -in_y;
        vec_nxt.y   = in_x;
        vec_nxt.acc = -QUARTER_TURN;
      end
    end
  end

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (rdy_c[0]) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_c[0] = vec_r;
  assign vld_c[0] = valid_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    atl_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld_c[i]),
      .in_ready (rdy_c[i]),
      .in_vec   (vec_c[i]),
      .out_valid(vld_c[i+1]),
      .out_ready(rdy_c[i+1]),
      .out_vec  (vec_c[i+1])
    );
  end

  assign rdy_c[STEPS] = out_ready;
  assign out_valid    = vld_c[STEPS];
  assign out_vec      = vec_c[STEPS];

endmodule

// ===== sv/atl_gain.sv =====
// ----------------------------------------------------------------------------
// atl_gain: gain correction between the roll and pitch chains
// Scales the roll magnitude by the inverse CORDIC gain, rounds the roll
// angle, and forms the pitch operands from the magnitude and -X.
// ----------------------------------------------------------------------------
module atl_gain (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  atl_pkg::atl_vec_t                in_vec,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [atl_pkg::VEC_W-1:0] out_x,
  output logic signed [atl_pkg::VEC_W-1:0] out_y,
  output logic [atl_pkg::SIDE_W-1:0]       out_side
);
  import atl_pkg::*;

  localparam int PROD_W = VEC_W + 18;

  logic                    valid_r, valid_nxt;
  logic                    load;
  logic signed [PROD_W-1:0] prod;
  logic signed [VEC_W-1:0] ax_ext;
  logic signed [15:0]      roll;
  logic signed [VEC_W-1:0] x_r, y_r;
  logic [SIDE_W-1:0]       side_r;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    prod   = in_vec.x * GAIN_INV;
    ax_ext = VEC_W'($signed(in_vec.side));
    roll   = in_vec.zero ? 16'sd0 : atl_round_sat(in_vec.acc, ROLL_LIM);
  end

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // The side word arrives holding X and leaves holding the rounded roll.
  always_ff @(posedge clk) begin
    if (load) begin
      x_r    <= $signed(prod[VEC_W+15:16]);
      y_r    <= -(ax_ext <<< FRAC_BITS);
      side_r <= roll;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_side  = side_r;

endmodule

// ===== sv/accel_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles: roll and pitch from a three-axis accelerometer sample
// Roll = atan2(Y, Z) and pitch = atan2(-X, |Y,Z|) in centidegrees, by two
// chained fixed-point vectoring CORDICs.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock and returns one result word per
// sample, in order. Every stage is a register with its own valid bit, so the
// block accepts a word every cycle as long as the result side keeps up, and
// it keeps filling its empty stages while a result waits. With STEPS =
// min(CORDIC_STEPS, 24), the stages in order are a quadrant stage
// and STEPS iteration cells for roll, a gain multiply stage, a quadrant stage
// and STEPS cells for pitch, and the output register.
module accel_tilt_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_centideg,
  output logic signed [14:0] out_pitch_centideg
);
  import atl_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic                    roll_in_x_unused;
  logic signed [VEC_W-1:0] roll_x, roll_y;
  logic                    roll_valid, roll_ready;
  atl_vec_t                roll_vec;
  logic                    gain_valid, gain_ready;
  logic signed [VEC_W-1:0] gain_x, gain_y;
  logic [SIDE_W-1:0]       gain_side;
  logic                    pitch_valid, pitch_ready;
  atl_vec_t                pitch_vec;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;
  logic signed [15:0]      pitch_full;
  logic signed [15:0]      roll_out_r;
  logic signed [14:0]      pitch_out_r;

  assign roll_in_x_unused = 1'b0;
  assign roll_x = VEC_W'(in_axis_z) <<< FRAC_BITS;
  assign roll_y = VEC_W'(in_axis_y) <<< FRAC_BITS;

  atl_cordic #(
    .STEPS(STEPS)
  ) u_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid || roll_in_x_unused),
    .in_ready (in_ready),
    .in_x     (roll_x),
    .in_y     (roll_y),
    .in_side  (in_axis_x),
    .out_valid(roll_valid),
    .out_ready(roll_ready),
    .out_vec  (roll_vec)
  );

  atl_gain u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (roll_valid),
    .in_ready (roll_ready),
    .in_vec   (roll_vec),
    .out_valid(gain_valid),
    .out_ready(gain_ready),
    .out_x    (gain_x),
    .out_y    (gain_y),
    .out_side (gain_side)
  );

  atl_cordic #(
    .STEPS(STEPS)
  ) u_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (gain_valid),
    .in_ready (gain_ready),
    .in_x     (gain_x),
    .in_y     (gain_y),
    .in_side  (gain_side),
    .out_valid(pitch_valid),
    .out_ready(pitch_ready),
    .out_vec  (pitch_vec)
  );

  // Output register: pitch rounding and clamping, roll rides in the side word.
  assign pitch_ready = !out_valid_r || out_ready;
  assign out_load    = pitch_valid && pitch_ready;

  always_comb begin
    pitch_full = pitch_vec.zero ? 16'sd0 : atl_round_sat(pitch_vec.acc, PITCH_LIM);
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      roll_out_r  <= $signed(pitch_vec.side);
      pitch_out_r <= pitch_full[14:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_roll_centideg  = roll_out_r;
  assign out_pitch_centideg = pitch_out_r;

  // The input side only stalls when every stage is full and the result waits.
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the pipeline has room");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_centideg <= 16'sd18000 && out_roll_centideg >= -16'sd18000))
    else $error("roll result out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_centideg <= 15'sd9000 && out_pitch_centideg >= -15'sd9000))
    else $error("pitch result out of range");

  a_gain_mag_positive: assert property (@(posedge clk) disable iff (!rst_n)
    gain_valid |-> !gain_x[VEC_W-1])
    else $error("corrected magnitude is negative");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: accel_tilt_angles roll/pitch pipeline check
// Drives accelerometer samples through the valid/ready input, predicts roll
// and pitch with a bit-accurate CORDIC model of its own, and checks every
// result word in order. Directed corner cases come first, then random
// traffic with random idling on both sides and one long result-side stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int    CORDIC_STEPS = 16;
  localparam int    STEP_COUNT   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int    LATENCY      = 2 * STEP_COUNT + 4;
  localparam int    RANDOM_ITEMS = 800;
  localparam int    HOLD_CYCLES  = 200;
  localparam longint GAIN_Q16    = 39797;
  localparam longint QUARTER_Q16 = 64'sd9000 * 64'sd65536;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } tilt_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_axis_x;
  logic signed [15:0] in_axis_y;
  logic signed [15:0] in_axis_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_roll_centideg;
  logic signed [14:0] out_pitch_centideg;

  tilt_t angle_q[$];
  int    mismatches;
  bit    calm;
  int    hold_req;

  accel_tilt_angles #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_axis_x          (in_axis_x),
    .in_axis_y          (in_axis_y),
    .in_axis_z          (in_axis_z),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_roll_centideg  (out_roll_centideg),
    .out_pitch_centideg (out_pitch_centideg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // atan(2^-i) in centidegrees scaled by 2^16.
  function automatic longint atan_q16(input int i);
    case (i)
      0:  return 294912000;
      1:  return 174096719;
      2:  return 91987925;
      3:  return 46694507;
      4:  return 23437865;
      5:  return 11730358;
      6:  return 5866610;
      7:  return 2933484;
      8:  return 1466764;
      9:  return 733385;
      10: return 366693;
      11: return 183346;
      12: return 91673;
      13: return 45837;
      14: return 22918;
      15: return 11459;
      16: return 5730;
      17: return 2865;
      18: return 1432;
      19: return 716;
      20: return 358;
      21: return 179;
      22: return 90;
      default: return 45;
    endcase
  endfunction

  // Vectoring CORDIC: angle of (x, y) in centidegrees * 2^16, magnitude with gain.
  function automatic longint vector_angle(input longint xi, input longint yi,
                                          output longint mag);
    longint x, y, acc, t, xs, ys;
    x = xi;
    y = yi;
    acc = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        acc = QUARTER_Q16;
      end else begin
        x = -y;
        y = t;
        acc = -QUARTER_Q16;
      end
    end
    for (int i = 0; i < STEP_COUNT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + atan_q16(i);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - atan_q16(i);
      end
    end
    mag = x;
    return acc;
  endfunction

  function automatic longint round_clamp(input longint acc, input longint lim);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic tilt_t predict_tilt(input logic signed [15:0] ax,
                                         input logic signed [15:0] ay,
                                         input logic signed [15:0] az);
    tilt_t  t;
    longint mag_raw, mag, unused_mag, roll_acc, pitch_acc, r, p;
    roll_acc  = vector_angle(longint'(az) * 16384, longint'(ay) * 16384, mag_raw);
    mag       = (mag_raw * GAIN_Q16) >>> 16;
    pitch_acc = vector_angle(mag, -longint'(ax) * 16384, unused_mag);
    r = round_clamp(roll_acc, 18000);
    p = round_clamp(pitch_acc, 9000);
    t.ax = ax;
    t.ay = ay;
    t.az = az;
    t.roll = r[15:0];
    t.pitch = p[14:0];
    return t;
  endfunction

  // Sends one sample word. Valid stays high after acceptance until the next
  // word, an idle gap or the end of the stream replaces it in the same step.
  task automatic send_sample(input logic signed [15:0] ax,
                             input logic signed [15:0] ay,
                             input logic signed [15:0] az);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_axis_x <= ax;
    in_axis_y <= ay;
    in_axis_z <= az;
    do @(posedge clk); while (!in_ready);
    angle_q.push_back(predict_tilt(ax, ay, az));
    @(negedge clk);
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] random_axis(input int kind);
    logic signed [15:0] v;
    case (kind)
      0: v = $signed(16'($urandom_range(0, 6)) - 16'sd3);
      1: begin
        case ($urandom_range(0, 6))
          0: v = -16'sd32768;
          1: v = -16'sd32767;
          2: v = -16'sd1;
          3: v = 16'sd0;
          4: v = 16'sd1;
          5: v = 16'sd32766;
          default: v = 16'sd32767;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random_sample();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      send_sample(random_axis(2), random_axis(2), random_axis(2));
    end else if (kind <= 7) begin
      send_sample(random_axis(0), random_axis(0), random_axis(0));
    end else if (kind == 8) begin
      send_sample(random_axis(1), random_axis(1), random_axis(1));
    end else begin
      // One large component, the others tiny: pushes angles toward the limits.
      case ($urandom_range(0, 2))
        0: send_sample(random_axis(2), random_axis(0), random_axis(0));
        1: send_sample(random_axis(0), random_axis(2), random_axis(0));
        default: send_sample(random_axis(0), random_axis(0), random_axis(2));
      endcase
    end
  endtask

  task automatic test_corner_samples();
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd1);
    send_sample(16'sd0, 16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd1, 16'sd0);
    send_sample(16'sd0, -16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    // Roll right at or next to the half turn, where the residue may overshoot.
    send_sample(16'sd0, -16'sd1, -16'sd32768);
    send_sample(16'sd0, 16'sd0, -16'sd5);
    send_sample(16'sd0, 16'sd1, -16'sd32768);
    // Pitch at the quarter turn with no or only a tiny Y/Z magnitude.
    send_sample(16'sd32767, 16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd0, 16'sd1);
    send_sample(16'sd32767, 16'sd0, 16'sd1);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    send_sample(16'sd1, -16'sd1, 16'sd1);
    send_sample(-16'sd1, 16'sd1, -16'sd1);
    send_sample(16'sd12345, -16'sd2345, 16'sd16384);
    send_sample(-16'sd16384, 16'sd11585, 16'sd11585);
    end_stream();
  endtask

  task automatic test_random_samples();
    calm = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) calm = 1'b0;
      send_random_sample();
    end
    end_stream();
  endtask

  task automatic test_output_backpressure();
    hold_req = hold_req + 1;
    for (int n = 0; n < 80; n++) begin
      send_random_sample();
    end
    end_stream();
  endtask

  // Result-side readiness: random stalls, a calm stretch, and long holds on request.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    tilt_t want;
    if (rst_n && out_valid && out_ready) begin
      if (angle_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("Unexpected result word: roll %0d pitch %0d",
                   out_roll_centideg, out_pitch_centideg);
        end
      end else begin
        want = angle_q.pop_front();
        if (out_roll_centideg !== want.roll || out_pitch_centideg !== want.pitch) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("Mismatch for x=%0d y=%0d z=%0d: roll exp %0d got %0d, pitch exp %0d got %0d",
                     want.ax, want.ay, want.az, want.roll, out_roll_centideg,
                     want.pitch, out_pitch_centideg);
          end
        end
      end
    end
  end

  initial begin
    int waited;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_axis_x  = '0;
    in_axis_y  = '0;
    in_axis_z  = '0;
    mismatches = 0;
    calm       = 1'b0;
    hold_req   = 0;
    waited     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_samples();
    test_random_samples();
    test_output_backpressure();

    while (angle_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited = waited + 1;
    end
    repeat (LATENCY + 20) @(posedge clk);

    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/atl_pkg.sv
sv/atl_cordic_cell.sv
sv/atl_cordic.sv
sv/atl_gain.sv
sv/accel_tilt_angles.sv
verif/testbench.sv
